[rtl/uart_rb_pkg.sv]
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared types and codes for the uart ring buffer pair: item kinds, result
// status codes and the status and result records passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package uart_rb_pkg;

    localparam int unsigned FILL_W = 7;

    typedef enum logic [1:0] {
        KIND_RX_BYTE  = 2'd0,
        KIND_HOST_WR  = 2'd1,
        KIND_TX_EMPTY = 2'd2,
        KIND_HOST_RD  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    // queue occupancy flags as seen before the current item
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // result fields known at accept time, byte comes later from the store
    typedef struct packed {
        t_status             status;
        logic                to_line;
        logic                to_host;
        logic                irq_on;
        logic [FILL_W-1:0]   rx_fill;
        logic [FILL_W-1:0]   tx_fill;
    } t_meta;

endpackage

`default_nettype wire

[rtl/urb_queue.sv]
// ----------------------------------------------------------------------------
// urb_queue
// Circular byte queue with one unused slot: write and read pointers, a byte
// store with registered read data, full and empty flags and the fill level
// after the current push or pop.
// ----------------------------------------------------------------------------
`default_nettype none

module urb_queue #(
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic                           i_pop,
    input  wire logic [7:0]                     i_data,
    output uart_rb_pkg::t_q_status              o_status,
    output logic [7:0]                          o_rdata,
    output logic [uart_rb_pkg::FILL_W-1:0]      o_fill
);
    import uart_rb_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]      r_store [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PW-1:0]   n_wr_ptr, n_rd_ptr;
    logic [PW-1:0]   wr_inc, rd_inc;
    logic [PW:0]     fill_wide;
    logic [PW-1:0]   fill;
    logic [PW+FILL_W-1:0] fill_ext;
    logic            do_push, do_pop;

    always_comb begin
        wr_inc = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        rd_inc = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        o_status.full  = (wr_inc == r_rd_ptr);
        o_status.empty = (r_wr_ptr == r_rd_ptr);
        do_push = i_push && !o_status.full;
        do_pop  = i_pop && !o_status.empty;
        n_wr_ptr = do_push ? wr_inc : r_wr_ptr;
        n_rd_ptr = do_pop ? rd_inc : r_rd_ptr;
        // level after this item, wrapping around the depth
        fill_wide = {1'b0, n_wr_ptr} - {1'b0, n_rd_ptr};
        if (n_wr_ptr < n_rd_ptr) begin
            fill_wide = fill_wide + (PW + 1)'(DEPTH);
        end
        fill     = fill_wide[PW-1:0];
        fill_ext = {{FILL_W{1'b0}}, fill};
        o_fill   = fill_ext[FILL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

    // read data holds until the next pop
    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            o_rdata <= r_store[r_rd_ptr];
        end
    end

endmodule

`default_nettype wire

[rtl/uart_ring_buffer_pair_unit.sv]
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair_unit
// Receive and transmit byte queues between a serial line and a host, with
// the transmit-empty interrupt enable.
// ----------------------------------------------------------------------------
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: data, tuser: kind
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: byte, status, irq, fills
//                                               tuser: to_line, to_host
//
// one item per cycle sustained while m_axis_tready stays high; an accepted
// item waits in the read stage for its registered store read, then its result
// is loaded into the output register to be taken; pointers update at the
// accept edge; reset clears the pointers and valid flags and sets the
// interrupt enable, stores are not cleared and need no clearing pass
// s_axis_tready drops only while both the read stage and the output
// register hold results and m_axis_tready is low
// ----------------------------------------------------------------------------
`default_nettype none

module uart_ring_buffer_pair_unit #(
    parameter int unsigned RX_DEPTH = 128,
    parameter int unsigned TX_DEPTH = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] out_byte, [9:8] status,
                                             // [10] tx_irq_on, [17:11] rx_fill,
                                             // [24:18] tx_fill, rest zero
    output logic [1:0]       m_axis_tuser    // [0] to_line, [1] to_host
);
    import uart_rb_pkg::*;

    t_q_status          rx_st, tx_st;
    logic [7:0]         rx_rdata, tx_rdata;
    logic [FILL_W-1:0]  rx_fill, tx_fill;
    logic               acc, rx_push, rx_pop, tx_push, tx_pop;
    logic               r_irq_en, n_irq_en;
    t_kind              kind;
    t_meta              n_meta, r_p_meta, r_o_meta;
    logic               r_p_valid, r_o_valid;
    logic               o_load_ok, p_adv;
    logic [7:0]         p_byte, r_o_byte;

    assign o_load_ok     = !r_o_valid || m_axis_tready;
    assign p_adv         = r_p_valid && o_load_ok;
    assign s_axis_tready = !r_p_valid || o_load_ok;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign kind          = t_kind'(s_axis_tuser);

    always_comb begin
        rx_push  = 1'b0;
        rx_pop   = 1'b0;
        tx_push  = 1'b0;
        tx_pop   = 1'b0;
        n_irq_en = r_irq_en;
        n_meta.status  = ST_DONE;
        n_meta.to_line = 1'b0;
        n_meta.to_host = 1'b0;
        unique case (kind)
            KIND_RX_BYTE: begin
                rx_push = acc;
                if (rx_st.full) n_meta.status = ST_FULL;
            end
            KIND_HOST_WR: begin
                tx_push  = acc;
                n_irq_en = acc ? 1'b1 : r_irq_en;
                if (tx_st.full) n_meta.status = ST_FULL;
            end
            KIND_TX_EMPTY: begin
                if (!r_irq_en) begin
                    n_meta.status = ST_IGNORED;
                end else if (!tx_st.empty) begin
                    tx_pop = acc;
                    n_meta.to_line = 1'b1;
                end else begin
                    n_irq_en = acc ? 1'b0 : r_irq_en;
                    n_meta.status = ST_EMPTY;
                end
            end
            KIND_HOST_RD: begin
                if (!rx_st.empty) begin
                    rx_pop = acc;
                    n_meta.to_host = 1'b1;
                end else begin
                    n_meta.status = ST_EMPTY;
                end
            end
            default: ;
        endcase
        n_meta.irq_on  = n_irq_en;
        n_meta.rx_fill = rx_fill;
        n_meta.tx_fill = tx_fill;
    end

    urb_queue #(.DEPTH(RX_DEPTH)) u_rx_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (rx_push),
        .i_pop    (rx_pop),
        .i_data   (s_axis_tdata),
        .o_status (rx_st),
        .o_rdata  (rx_rdata),
        .o_fill   (rx_fill)
    );

    urb_queue #(.DEPTH(TX_DEPTH)) u_tx_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (tx_push),
        .i_pop    (tx_pop),
        .i_data   (s_axis_tdata),
        .o_status (tx_st),
        .o_rdata  (tx_rdata),
        .o_fill   (tx_fill)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_en  <= 1'b1;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_irq_en <= n_irq_en;
            if (acc) begin
                r_p_valid <= 1'b1;
            end else if (p_adv) begin
                r_p_valid <= 1'b0;
            end
            if (p_adv) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // store read data lines up with the stage holding its item
    assign p_byte = r_p_meta.to_line ? tx_rdata :
                    r_p_meta.to_host ? rx_rdata : 8'd0;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p_meta <= n_meta;
        end
        if (p_adv) begin
            r_o_meta <= r_p_meta;
            r_o_byte <= p_byte;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = {r_o_meta.to_host, r_o_meta.to_line};
    assign m_axis_tdata  = {7'd0, r_o_meta.tx_fill, r_o_meta.rx_fill,
                            r_o_meta.irq_on, r_o_meta.status, r_o_byte};

endmodule

`default_nettype wire

[rtl/urb_checker.sv]
// ----------------------------------------------------------------------------
// urb_checker
// Port-level checks on the result stream of the uart ring buffer pair.
// ----------------------------------------------------------------------------
`default_nettype none

module urb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);
    import uart_rb_pkg::*;

    logic moved;
    assign moved = m_axis_tuser[0] || m_axis_tuser[1];

    // a byte goes to one side at most
    a_one_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("byte sent to line and host at once");

    // no byte moved means a zero byte field
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !moved) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("nonzero byte with no destination");

    // a moved byte always completes normally
    a_moved_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && moved) |-> (m_axis_tdata[9:8] == ST_DONE))
        else $error("byte moved with a failure status");

    // ignored transmit-empty only happens with the enable clear
    a_ignored_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[9:8] == ST_IGNORED)) |-> !m_axis_tdata[10])
        else $error("ignored status with interrupt enable set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind uart_ring_buffer_pair_unit urb_checker u_urb_checker (.*);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart ring buffer pair testbench
// Streams line bytes, host writes, transmitter-empty events and host reads
// into the block under random idling and output back-pressure. A scoreboard
// keeps its own copy of both byte queues and the interrupt enable, predicts
// every result and compares it field by field with what comes out.
// ----------------------------------------------------------------------------

module testbench;

    import uart_rb_pkg::*;

    localparam int unsigned PTR_W          = 7;
    localparam int unsigned QDEPTH         = 2 ** PTR_W;
    localparam int unsigned RANDOM_ITEMS   = 1050;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 10;

    typedef enum int {
        MODE_RX_FILL,
        MODE_TX_FILL,
        MODE_DRAIN,
        MODE_MIX
    } t_mode;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              to_line;
        logic              to_host;
        t_status           status;
        logic              irq_on;
        logic [FILL_W-1:0] rx_fill;
        logic [FILL_W-1:0] tx_fill;
    } t_uart_result;

    class uart_rb_scoreboard;
        logic [7:0]       rx_bytes [QDEPTH];
        logic [7:0]       tx_bytes [QDEPTH];
        logic [PTR_W-1:0] rx_wr, rx_rd, tx_wr, tx_rd;
        logic             irq_en;
        t_uart_result     expected_results [$];
        int               errors;
        int               checked;
        int               seen_full, seen_empty, seen_ignored, seen_line, seen_host;

        function new();
            rx_wr = '0;
            rx_rd = '0;
            tx_wr = '0;
            tx_rd = '0;
            irq_en = 1'b1;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // queue pointers wrap on their own at this width
        function void note_item(t_kind kind, logic [7:0] data);
            t_uart_result r;
            r = '0;
            r.status = ST_DONE;
            case (kind)
                KIND_RX_BYTE: begin
                    if (PTR_W'(rx_wr + 1'b1) != rx_rd) begin
                        rx_bytes[rx_wr] = data;
                        rx_wr = rx_wr + 1'b1;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                KIND_HOST_WR: begin
                    if (PTR_W'(tx_wr + 1'b1) != tx_rd) begin
                        tx_bytes[tx_wr] = data;
                        tx_wr = tx_wr + 1'b1;
                    end else begin
                        r.status = ST_FULL;
                    end
                    // a refused byte still re-arms the drain
                    irq_en = 1'b1;
                end
                KIND_TX_EMPTY: begin
                    if (!irq_en) begin
                        r.status = ST_IGNORED;
                    end else if (tx_rd != tx_wr) begin
                        r.out_byte = tx_bytes[tx_rd];
                        r.to_line = 1'b1;
                        tx_rd = tx_rd + 1'b1;
                    end else begin
                        irq_en = 1'b0;
                        r.status = ST_EMPTY;
                    end
                end
                default: begin
                    if (rx_rd != rx_wr) begin
                        r.out_byte = rx_bytes[rx_rd];
                        r.to_host = 1'b1;
                        rx_rd = rx_rd + 1'b1;
                    end else begin
                        r.status = ST_EMPTY;
                    end
                end
            endcase
            r.irq_on = irq_en;
            r.rx_fill = FILL_W'(rx_wr - rx_rd);
            r.tx_fill = FILL_W'(tx_wr - tx_rd);
            expected_results.push_back(r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_item(logic [31:0] tdata, logic [1:0] tuser);
            t_uart_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            check_field("out_byte", want.out_byte, tdata[7:0]);
            check_field("status", want.status, tdata[9:8]);
            check_field("tx_irq_on", want.irq_on, tdata[10]);
            check_field("rx_fill", want.rx_fill, tdata[17:11]);
            check_field("tx_fill", want.tx_fill, tdata[24:18]);
            check_field("tdata pad", 0, tdata[31:25]);
            check_field("to_line", want.to_line, tuser[0]);
            check_field("to_host", want.to_host, tuser[1]);
            case (want.status)
                ST_FULL:    seen_full++;
                ST_EMPTY:   seen_empty++;
                ST_IGNORED: seen_ignored++;
                default:    ;
            endcase
            if (want.to_line) seen_line++;
            if (want.to_host) seen_host++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] data
    logic [1:0]  s_axis_tuser = '0;    // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [7:0] out_byte, [9:8] status, [10] tx_irq_on,
                                       // [17:11] rx_fill, [24:18] tx_fill
    logic [1:0]  m_axis_tuser;         // [0] to_line, [1] to_host

    logic        quiet = 1'b0;
    int          idle_cycles = 0;
    int          items_sent = 0;

    uart_rb_scoreboard sb = new();

    uart_ring_buffer_pair_unit #(
        .RX_DEPTH(QDEPTH),
        .TX_DEPTH(QDEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // values read here are the ones present just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(t_kind'(s_axis_tuser), s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_item(m_axis_tdata, m_axis_tuser);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= 9);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no item moved for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_item(input t_kind kind, input logic [7:0] data);
        while (!quiet && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_kind pick_kind(t_mode mode);
        int unsigned roll;
        roll = $urandom_range(99);
        case (mode)
            MODE_RX_FILL: return (roll < 85) ? KIND_RX_BYTE : t_kind'($urandom_range(3));
            MODE_TX_FILL: return (roll < 85) ? KIND_HOST_WR : t_kind'($urandom_range(3));
            MODE_DRAIN: begin
                if (roll < 45) return KIND_HOST_RD;
                if (roll < 90) return KIND_TX_EMPTY;
                return t_kind'($urandom_range(3));
            end
            default: return t_kind'($urandom_range(3));
        endcase
    endfunction

    initial begin
        int    seg;
        int    seg_len;
        t_mode mode;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queues, enable clearing and the ignored event
        send_item(KIND_HOST_RD,  8'hFF);
        send_item(KIND_TX_EMPTY, 8'h00);
        send_item(KIND_TX_EMPTY, 8'hFF);
        send_item(KIND_HOST_WR,  8'h00);
        send_item(KIND_HOST_WR,  8'hFF);
        send_item(KIND_TX_EMPTY, 8'hA5);
        send_item(KIND_TX_EMPTY, 8'h5A);
        send_item(KIND_TX_EMPTY, 8'h00);
        send_item(KIND_TX_EMPTY, 8'h00);
        send_item(KIND_HOST_WR,  8'h5A);
        send_item(KIND_TX_EMPTY, 8'hFF);
        send_item(KIND_TX_EMPTY, 8'hFF);
        send_item(KIND_RX_BYTE,  8'h00);
        send_item(KIND_RX_BYTE,  8'hFF);
        send_item(KIND_RX_BYTE,  8'h81);
        send_item(KIND_HOST_RD,  8'h00);
        send_item(KIND_HOST_RD,  8'hFF);
        send_item(KIND_HOST_RD,  8'h7E);
        send_item(KIND_HOST_RD,  8'h00);

        // hold the sender until the pipeline has emptied
        wait_drained();

        items_sent = 0;
        seg = 0;
        while (items_sent < RANDOM_ITEMS) begin
            // first segments run both queues into full, one later stretch never idles
            if (seg == 0) begin
                mode = MODE_RX_FILL;
                seg_len = 140;
            end else if (seg == 1) begin
                mode = MODE_TX_FILL;
                seg_len = 140;
            end else if (seg == 3) begin
                mode = MODE_MIX;
                seg_len = 200;
            end else begin
                mode = t_mode'($urandom_range(3));
                seg_len = $urandom_range(20, 160);
            end
            quiet <= (seg == 3);
            repeat (seg_len) begin
                if (items_sent >= RANDOM_ITEMS) break;
                if (seg < 2) begin
                    send_item((seg == 0) ? KIND_RX_BYTE : KIND_HOST_WR, 8'($urandom));
                end else begin
                    send_item(pick_kind(mode), 8'($urandom));
                end
            end
            if (seg == 1) wait_drained();
            seg++;
        end
        quiet <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0", $time, sb.pending());
            sb.errors++;
        end

        $display("checked %0d results: %0d to line, %0d to host",
                 sb.checked, sb.seen_line, sb.seen_host);
        $display("queue full %0d, queue empty %0d, ignored %0d, mismatches %0d",
                 sb.seen_full, sb.seen_empty, sb.seen_ignored, sb.errors);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/uart_rb_pkg.sv
rtl/urb_queue.sv
rtl/uart_ring_buffer_pair_unit.sv
rtl/urb_checker.sv
test/testbench.sv
